// ----- rtl/mva_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mva_pkg: shared types and constants of the modular vector alu
// Field widths, the command codes and the reset modulus.
// ----------------------------------------------------------------------------
package mva_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned CMD_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_NEG = 2'd2,
    CMD_MUL = 2'd3
  } cmd_t;

  typedef logic [DATA_W-1:0] data_t;

  localparam data_t MOD_RESET = 32'd2;
  // floor(2^64 / 2), the reciprocal that belongs to the reset modulus
  localparam logic [2*DATA_W-1:0] MU_RESET = 64'h8000_0000_0000_0000;

endpackage : mva_pkg
`default_nettype wire

// ----- rtl/mva_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mva_in_if: request channel of the modular vector alu
// Command, two operands and the last-element mark.
// ----------------------------------------------------------------------------
interface mva_in_if;
  import mva_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  command;
  data_t operand_x;
  data_t operand_y;
  logic  last_element;

  modport source (output valid, command, operand_x, operand_y, last_element, input ready);
  modport sink   (input valid, command, operand_x, operand_y, last_element, output ready);

endinterface : mva_in_if
`default_nettype wire

// ----- rtl/mva_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mva_out_if: result channel of the modular vector alu
// Reduced result element and the copied last mark.
// ----------------------------------------------------------------------------
interface mva_out_if;
  import mva_pkg::*;

  logic  valid;
  logic  ready;
  data_t result;
  logic  last_result;

  modport source (output valid, result, last_result, input ready);
  modport sink   (input valid, result, last_result, output ready);

endinterface : mva_out_if
`default_nettype wire

// ----- rtl/modular_vector_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// modular_vector_alu: element-wise add, subtract, negate and multiply mod m
// Every op is mapped onto one unsigned value and a negate flag, then reduced
// by a pipelined Barrett stage using mu = floor(2^64 / m).
// ----------------------------------------------------------------------------
//  channel   | direction | handshake        | payload
//  in_chan   | in        | valid / ready    | command, operand_x, operand_y, last_element
//  out_chan  | out       | valid / ready    | result, last_result
//  cfg       | in        | cfg_we           | cfg_wdata (modulus)
//
//  One request per cycle while in_chan.ready is high; each passes stages 0 to 8 to result valid.
//  Writing a modulus of two or more starts the bit-serial reciprocal divider:
//  in_chan.ready is low while it runs, one quotient bit per cycle.
//  Reset loads modulus 2 together with its reciprocal, so no wait follows it.
//  Each stage holds its request while the next one is full and stalled.
// ----------------------------------------------------------------------------
module modular_vector_alu (
  input  wire logic           clk,
  input  wire logic           rst_n,
  mva_in_if.sink              in_chan,
  mva_out_if.source           out_chan,
  input  wire logic           cfg_we,
  input  wire mva_pkg::data_t cfg_wdata
);
  import mva_pkg::*;

  localparam int unsigned NSTG   = 9;
  localparam int unsigned DW2    = 2 * DATA_W;
  localparam int unsigned RW     = DATA_W + 2;
  localparam logic [6:0]  DIV_TOP = 7'(DW2);

  typedef struct packed {
    logic neg;
    logic last;
  } side_t;

  // --------------------------------------------------------------------------
  // modulus register and reciprocal divider
  // --------------------------------------------------------------------------
  data_t            modulus_r;
  logic [DW2-1:0]   mu_r;
  logic             busy_r;
  logic [6:0]       cnt_r;
  data_t            rem_r;
  logic [DATA_W:0]  rem_shift;
  logic [DATA_W:0]  rem_diff;
  logic             qbit;

  assign rem_shift = {rem_r, (cnt_r == DIV_TOP)};
  assign rem_diff  = rem_shift - {1'b0, modulus_r};
  assign qbit      = ~rem_diff[DATA_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MOD_RESET;
      mu_r      <= MU_RESET;
      busy_r    <= 1'b0;
      cnt_r     <= '0;
      rem_r     <= '0;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
      busy_r    <= (cfg_wdata > data_t'(1));
      cnt_r     <= DIV_TOP;
      rem_r     <= '0;
      mu_r      <= '0;
    end else if (busy_r) begin
      // dividend is 2^64: a single one at the top bit, zeros below
      rem_r  <= qbit ? rem_diff[DATA_W-1:0] : rem_shift[DATA_W-1:0];
      mu_r   <= {mu_r[DW2-2:0], qbit};
      cnt_r  <= cnt_r - 7'd1;
      busy_r <= (cnt_r != 7'd0);
    end
  end

  // --------------------------------------------------------------------------
  // stage flow control
  // --------------------------------------------------------------------------
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   en;
  logic            in_acc;
  side_t           side_r [NSTG];
  side_t           side_nxt;

  always_comb begin
    en[NSTG] = out_chan.ready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      en[k] = ~vld_r[k] | en[k+1];
    end
  end

  assign in_chan.ready = en[0] & ~busy_r;
  assign in_acc        = in_chan.valid & in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_acc;
      end
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side_r[0] <= side_nxt;
    end
    for (int k = 1; k < NSTG; k++) begin
      if (en[k]) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: fold every command into one unsigned value and a negate flag
  // --------------------------------------------------------------------------
  logic [DATA_W:0] sum_xy;
  logic [DATA_W:0] dif_xy;
  logic [DATA_W:0] dif_yx;
  logic [DATA_W:0] n0_nxt;
  logic            mul0_nxt;
  logic [DATA_W:0] s0_n_r;
  logic            s0_mul_r;
  data_t           s0_x_r;
  data_t           s0_y_r;

  assign sum_xy = {1'b0, in_chan.operand_x} + {1'b0, in_chan.operand_y};
  assign dif_xy = {1'b0, in_chan.operand_x} - {1'b0, in_chan.operand_y};
  assign dif_yx = {1'b0, in_chan.operand_y} - {1'b0, in_chan.operand_x};

  always_comb begin
    side_nxt.last = in_chan.last_element;
    side_nxt.neg  = 1'b0;
    n0_nxt        = sum_xy;
    mul0_nxt      = 1'b0;
    case (in_chan.command)
      CMD_ADD: begin
        n0_nxt = sum_xy;
      end
      CMD_SUB: begin
        // a negative difference is reduced by magnitude and negated at the end
        side_nxt.neg = dif_xy[DATA_W];
        n0_nxt       = dif_xy[DATA_W] ? dif_yx : dif_xy;
      end
      CMD_NEG: begin
        side_nxt.neg = 1'b1;
        n0_nxt       = {1'b0, in_chan.operand_x};
      end
      CMD_MUL: begin
        mul0_nxt = 1'b1;
      end
      default: begin
        n0_nxt = sum_xy;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_n_r   <= n0_nxt;
      s0_mul_r <= mul0_nxt;
      s0_x_r   <= in_chan.operand_x;
      s0_y_r   <= in_chan.operand_y;
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: full product for multiply
  // --------------------------------------------------------------------------
  logic [DW2-1:0] s1_n_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_n_r <= s0_mul_r ? (s0_x_r * s0_y_r) : {{(DW2-DATA_W-1){1'b0}}, s0_n_r};
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: partial products of n * mu
  // --------------------------------------------------------------------------
  logic [DW2-1:0] s2_ll_r;
  logic [DW2-1:0] s2_lh_r;
  logic [DW2-1:0] s2_hl_r;
  logic [DW2-1:0] s2_hh_r;
  logic [RW-1:0]  s2_nlo_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s2_ll_r  <= s1_n_r[DATA_W-1:0]   * mu_r[DATA_W-1:0];
      s2_lh_r  <= s1_n_r[DATA_W-1:0]   * mu_r[DW2-1:DATA_W];
      s2_hl_r  <= s1_n_r[DW2-1:DATA_W] * mu_r[DATA_W-1:0];
      s2_hh_r  <= s1_n_r[DW2-1:DATA_W] * mu_r[DW2-1:DATA_W];
      s2_nlo_r <= s1_n_r[RW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: column sums; only the low 34 bits of the quotient are needed
  // --------------------------------------------------------------------------
  logic [RW-1:0] mid_sum;
  logic [1:0]    s3_cy_r;
  logic [RW-1:0] s3_sum_r;
  logic [RW-1:0] s3_nlo_r;

  assign mid_sum = {2'b00, s2_ll_r[DW2-1:DATA_W]} + {2'b00, s2_lh_r[DATA_W-1:0]}
                 + {2'b00, s2_hl_r[DATA_W-1:0]};

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_cy_r  <= mid_sum[RW-1:DATA_W];
      s3_sum_r <= s2_hh_r[RW-1:0] + {2'b00, s2_lh_r[DW2-1:DATA_W]}
                + {2'b00, s2_hl_r[DW2-1:DATA_W]};
      s3_nlo_r <= s2_nlo_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: quotient estimate, at most one below the true quotient
  // --------------------------------------------------------------------------
  logic [RW-1:0] s4_q_r;
  logic [RW-1:0] s4_nlo_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_q_r   <= s3_sum_r + {{(RW-2){1'b0}}, s3_cy_r};
      s4_nlo_r <= s3_nlo_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: q * m, low 34 bits
  // --------------------------------------------------------------------------
  logic [DW2-1:0] s5_p_r;
  logic [3:0]     top_prod;
  logic [1:0]     s5_h_r;
  logic [RW-1:0]  s5_nlo_r;

  assign top_prod = s4_q_r[RW-1:DATA_W] * modulus_r[1:0];

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_p_r   <= s4_q_r[DATA_W-1:0] * modulus_r;
      s5_h_r   <= top_prod[1:0];
      s5_nlo_r <= s4_nlo_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 6: remainder estimate, below 2m
  // --------------------------------------------------------------------------
  logic [RW-1:0] qm_lo;
  logic [RW-1:0] s6_r_r;

  assign qm_lo = {s5_p_r[RW-1:DATA_W] + s5_h_r, s5_p_r[DATA_W-1:0]};

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_r_r <= s5_nlo_r - qm_lo;
    end
  end

  // --------------------------------------------------------------------------
  // stage 7: final correction
  // --------------------------------------------------------------------------
  logic [RW-1:0] r_corr;
  data_t         s7_r_r;

  assign r_corr = s6_r_r - {2'b00, modulus_r};

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_r_r <= (s6_r_r >= {2'b00, modulus_r}) ? r_corr[DATA_W-1:0]
                                               : s6_r_r[DATA_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // stage 8: negate where needed, output register
  // --------------------------------------------------------------------------
  data_t res_nxt;
  data_t s8_res_r;

  always_comb begin
    // modulus zero or one has only the residue 0
    if (modulus_r < data_t'(2)) begin
      res_nxt = '0;
    end else if (side_r[7].neg && (s7_r_r != '0)) begin
      res_nxt = modulus_r - s7_r_r;
    end else begin
      res_nxt = s7_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s8_res_r <= res_nxt;
    end
  end

  assign out_chan.valid       = vld_r[NSTG-1];
  assign out_chan.result      = s8_res_r;
  assign out_chan.last_result = side_r[NSTG-1].last;

endmodule : modular_vector_alu
`default_nettype wire
